### src/lamp_switch_display_io_board_assert.svh
// Assertion macros used by the board update module.
`ifndef LAMP_SWITCH_DISPLAY_IO_BOARD_ASSERT_SVH
`define LAMP_SWITCH_DISPLAY_IO_BOARD_ASSERT_SVH

// Check a property on every clock outside reset.
`define LSDIO_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define LSDIO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lsdio_pkg.sv
package lsdio_pkg;

    localparam int DIGITS_PER_BANK_DEF = 16;
    localparam int LAMP_COLUMNS_DEF    = 8;

    localparam int ACTION_W  = 4;
    localparam int DATA_W    = 16;
    localparam int SWITCH_W  = 8;
    localparam int READ_W    = 8;
    localparam int COL_W     = 3;
    localparam int ROW_W     = 8;
    localparam int SOL_W     = 32;
    localparam int DISP_W    = 4;
    localparam int SEG_POS_W = 5;
    localparam int SEG_W     = 16;
    localparam int IRQ_W     = 4;
    localparam int SUM_W     = 5;

    localparam logic [READ_W-1:0] IRQ_BASE_LO = 8'h88;
    localparam logic [READ_W-1:0] IRQ_BASE_HI = 8'(8'h98 - 8'h08);
    localparam logic [IRQ_W-1:0]  IRQ_RESET   = 4'd1;
    localparam int                SYNC_BIT    = 10;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SWITCH_READ = 4'd0,
        ACT_LAMP_STROBE = 4'd1,
        ACT_LAMP_ROW    = 4'd2,
        ACT_SOL_LOW     = 4'd3,
        ACT_SOL_HIGH    = 4'd4,
        ACT_CONTROL     = 4'd5,
        ACT_DISP_BANK0  = 4'd6,
        ACT_DISP_BANK1  = 4'd7,
        ACT_IRQ_ACK     = 4'd8
    } action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   bus_data;
        logic [SWITCH_W-1:0] switch_lines;
    } bus_item_t;

    typedef struct packed {
        logic [READ_W-1:0]    read_value;
        logic [COL_W-1:0]     lamp_column;
        logic [ROW_W-1:0]     lamp_rows;
        logic [SOL_W-1:0]     solenoid_word;
        logic [DISP_W-1:0]    display_column;
        logic [SEG_POS_W-1:0] segment_position;
        logic [SEG_W-1:0]     segment_pattern;
    } result_item_t;

    function automatic logic [SWITCH_W-1:0] reverse8(input logic [SWITCH_W-1:0] v);
        logic [SWITCH_W-1:0] r;
        for (int i = 0; i < SWITCH_W; i++)
        begin
            r[SWITCH_W-1-i] = v[i];
        end
        return r;
    endfunction

    // Sum of the positions of the set bits.
    function automatic logic [SUM_W-1:0] bit_position_sum(input logic [7:0] v);
        logic [SUM_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                sum = sum + SUM_W'(i);
            end
        end
        return sum;
    endfunction

    function automatic logic [SEG_W-1:0] remap_segments(input logic [DATA_W-1:0] d);
        logic [SEG_W-1:0] s;
        s        = '0;
        s[0]     = d[0] | d[1];
        s[1]     = d[2];
        s[2]     = d[3];
        s[3]     = d[4] | d[5];
        s[4]     = d[6];
        s[5]     = d[7];
        s[6]     = d[15];
        s[14:8]  = d[14:8];
        return s;
    endfunction

endpackage

### src/lsdio_bus_if.sv
interface lsdio_bus_if;
    logic                          valid;
    logic                          ready;
    logic [lsdio_pkg::ACTION_W-1:0] action;
    logic [lsdio_pkg::DATA_W-1:0]   bus_data;
    logic [lsdio_pkg::SWITCH_W-1:0] switch_lines;

    modport source (output valid, output action, output bus_data, output switch_lines,
                    input ready);
    modport sink (input valid, input action, input bus_data, input switch_lines,
                  output ready);
endinterface

### src/lsdio_result_if.sv
interface lsdio_result_if;
    logic                           valid;
    logic                           ready;
    logic [lsdio_pkg::READ_W-1:0]    read_value;
    logic [lsdio_pkg::COL_W-1:0]     lamp_column;
    logic [lsdio_pkg::ROW_W-1:0]     lamp_rows;
    logic [lsdio_pkg::SOL_W-1:0]     solenoid_word;
    logic [lsdio_pkg::DISP_W-1:0]    display_column;
    logic [lsdio_pkg::SEG_POS_W-1:0] segment_position;
    logic [lsdio_pkg::SEG_W-1:0]     segment_pattern;

    modport source (output valid, output read_value, output lamp_column, output lamp_rows,
                    output solenoid_word, output display_column, output segment_position,
                    output segment_pattern, input ready);
    modport sink (input valid, input read_value, input lamp_column, input lamp_rows,
                  input solenoid_word, input display_column, input segment_position,
                  input segment_pattern, output ready);
endinterface

### src/lsdio_update.sv
`include "lamp_switch_display_io_board_assert.svh"

module lsdio_update #(
    parameter int DIGITS_PER_BANK = lsdio_pkg::DIGITS_PER_BANK_DEF,
    parameter int LAMP_COLUMNS    = lsdio_pkg::LAMP_COLUMNS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  lsdio_pkg::bus_item_t    item,
    output lsdio_pkg::result_item_t res
);

    localparam int LIDX_W = $clog2(LAMP_COLUMNS);
    localparam int DIG_W  = $clog2(DIGITS_PER_BANK);
    localparam logic [DIG_W:0]                  BANK_OFFSET = (DIG_W+1)'(DIGITS_PER_BANK);
    localparam logic [DIG_W-1:0]                DIGIT_LAST  = DIG_W'(DIGITS_PER_BANK - 1);
    localparam logic [lsdio_pkg::SUM_W-1:0]     STROBE_MAX  =
        lsdio_pkg::SUM_W'(LAMP_COLUMNS - 1);

    logic [lsdio_pkg::IRQ_W-1:0] irq_count_reg, irq_count_next;
    logic [lsdio_pkg::COL_W-1:0] strobe_reg, strobe_next;
    logic [lsdio_pkg::ROW_W-1:0] lamp_reg [LAMP_COLUMNS];
    logic [lsdio_pkg::ROW_W-1:0] lamp_next [LAMP_COLUMNS];
    logic [lsdio_pkg::SOL_W-1:0] sol_reg, sol_next;
    logic                        synced_reg, synced_next;
    logic [DIG_W-1:0]            digit_reg, digit_next;

    logic [lsdio_pkg::SUM_W-1:0]          position_sum;
    logic [lsdio_pkg::SUM_W-1:0]          strobe_clamp;
    logic [DIG_W-1:0]                     digit_advance;
    logic [DIG_W:0]                       seg_pos_sum;
    logic [lsdio_pkg::SEG_POS_W+DIG_W:0]  seg_pos_ext;
    logic [lsdio_pkg::DISP_W+DIG_W-1:0]   digit_ext;
    logic [lsdio_pkg::READ_W-1:0]         read_value;
    logic [lsdio_pkg::SEG_W-1:0]          seg_pat;

    assign position_sum  = lsdio_pkg::bit_position_sum(item.bus_data[15:8]);
    assign strobe_clamp  = (position_sum > STROBE_MAX) ? STROBE_MAX : position_sum;
    assign digit_advance = (digit_reg == DIGIT_LAST) ? '0 : digit_reg + 1'b1;

    always_comb
    begin
        irq_count_next = irq_count_reg;
        strobe_next    = strobe_reg;
        lamp_next      = lamp_reg;
        sol_next       = sol_reg;
        synced_next    = synced_reg;
        digit_next     = digit_reg;
        read_value     = '0;
        seg_pos_sum    = '0;
        seg_pat        = '0;
        case (lsdio_pkg::action_t'(item.action))
            lsdio_pkg::ACT_SWITCH_READ:
            begin
                read_value = lsdio_pkg::reverse8(item.switch_lines);
            end
            lsdio_pkg::ACT_LAMP_STROBE:
            begin
                strobe_next = strobe_clamp[lsdio_pkg::COL_W-1:0];
            end
            lsdio_pkg::ACT_LAMP_ROW:
            begin
                lamp_next[strobe_reg[LIDX_W-1:0]] = item.bus_data[15:8];
            end
            lsdio_pkg::ACT_SOL_LOW:
            begin
                sol_next = {sol_reg[31:16], item.bus_data};
            end
            lsdio_pkg::ACT_SOL_HIGH:
            begin
                sol_next = {item.bus_data, sol_reg[15:0]};
            end
            lsdio_pkg::ACT_CONTROL:
            begin
                if (synced_reg)
                begin
                    digit_next = digit_advance;
                end
                // sync pulse: restart the digit scan
                if (item.bus_data[lsdio_pkg::SYNC_BIT])
                begin
                    synced_next = 1'b1;
                    digit_next  = '0;
                end
            end
            lsdio_pkg::ACT_DISP_BANK0, lsdio_pkg::ACT_DISP_BANK1:
            begin
                seg_pat     = lsdio_pkg::remap_segments(item.bus_data);
                seg_pos_sum = {1'b0, digit_reg} +
                    ((item.action == lsdio_pkg::ACT_DISP_BANK1) ? BANK_OFFSET : '0);
            end
            lsdio_pkg::ACT_IRQ_ACK:
            begin
                read_value = (irq_count_reg[lsdio_pkg::IRQ_W-1] ? lsdio_pkg::IRQ_BASE_HI
                                                                : lsdio_pkg::IRQ_BASE_LO)
                             + lsdio_pkg::READ_W'(irq_count_reg);
                irq_count_next = irq_count_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign seg_pos_ext = {lsdio_pkg::SEG_POS_W'(0), seg_pos_sum};
    assign digit_ext   = {lsdio_pkg::DISP_W'(0), digit_next};

    always_comb
    begin
        res.read_value       = read_value;
        res.lamp_column      = strobe_next;
        res.lamp_rows        = lamp_next[strobe_next[LIDX_W-1:0]];
        res.solenoid_word    = sol_next;
        res.display_column   = digit_ext[lsdio_pkg::DISP_W-1:0];
        res.segment_position = seg_pos_ext[lsdio_pkg::SEG_POS_W-1:0];
        res.segment_pattern  = seg_pat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_count_reg <= lsdio_pkg::IRQ_RESET;
            strobe_reg    <= '0;
            for (int i = 0; i < LAMP_COLUMNS; i++)
            begin
                lamp_reg[i] <= '0;
            end
            sol_reg       <= '0;
            synced_reg    <= 1'b0;
            digit_reg     <= '0;
        end
        else if (fire)
        begin
            irq_count_reg <= irq_count_next;
            strobe_reg    <= strobe_next;
            lamp_reg      <= lamp_next;
            sol_reg       <= sol_next;
            synced_reg    <= synced_next;
            digit_reg     <= digit_next;
        end
    end

    `LSDIO_ASSERT(a_strobe_range, 32'(strobe_reg) < LAMP_COLUMNS, "strobe column out of range")
    `LSDIO_ASSERT(a_digit_range, 32'(digit_reg) < DIGITS_PER_BANK, "digit column out of range")
    `LSDIO_ASSERT_NEXT(a_irq_advance, fire && item.action == lsdio_pkg::ACT_IRQ_ACK, irq_count_reg == $past(irq_count_reg) + 1'b1, "vector count did not advance")
    `LSDIO_ASSERT_NEXT(a_idle_hold, !fire, $stable(sol_reg) && $stable(strobe_reg) && $stable(digit_reg) && $stable(irq_count_reg), "state moved without an item")

endmodule

### src/lamp_switch_display_io_board.sv
// Path: an accepted bus item goes through the input register, then the result register.
// Throughput: one item per cycle while result.ready holds; the result register frees as its item is taken.
// All board state updates in the single pass between the two registers.
// Reset: asynchronous, active low; clears state and lamp rows to zero,
// and sets the interrupt vector count so the first acknowledge returns 0x89.
module lamp_switch_display_io_board #(
    parameter int DIGITS_PER_BANK = lsdio_pkg::DIGITS_PER_BANK_DEF,
    parameter int LAMP_COLUMNS    = lsdio_pkg::LAMP_COLUMNS_DEF
) (
    input logic            clk,
    input logic            rst_n,
    lsdio_bus_if.sink      bus,
    lsdio_result_if.source result
);

    logic                    s1_valid_reg;
    lsdio_pkg::bus_item_t    s1_item_reg;
    logic                    out_valid_reg;
    lsdio_pkg::result_item_t out_item_reg;
    lsdio_pkg::result_item_t upd_res;

    logic out_free;
    logic s1_fire;
    logic bus_fire;

    assign out_free  = !out_valid_reg || result.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign bus.ready = !s1_valid_reg || out_free;
    assign bus_fire  = bus.valid && bus.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (bus.ready)
            begin
                s1_valid_reg <= bus.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bus_fire)
        begin
            s1_item_reg <= '{action:       bus.action,
                             bus_data:     bus.bus_data,
                             switch_lines: bus.switch_lines};
        end
        if (s1_fire)
        begin
            out_item_reg <= upd_res;
        end
    end

    lsdio_update #(
        .DIGITS_PER_BANK (DIGITS_PER_BANK),
        .LAMP_COLUMNS    (LAMP_COLUMNS)
    ) u_update (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .item  (s1_item_reg),
        .res   (upd_res)
    );

    assign result.valid            = out_valid_reg;
    assign result.read_value       = out_item_reg.read_value;
    assign result.lamp_column      = out_item_reg.lamp_column;
    assign result.lamp_rows        = out_item_reg.lamp_rows;
    assign result.solenoid_word    = out_item_reg.solenoid_word;
    assign result.display_column   = out_item_reg.display_column;
    assign result.segment_position = out_item_reg.segment_position;
    assign result.segment_pattern  = out_item_reg.segment_pattern;

endmodule

### sim/lamp_switch_display_io_board_test.sv
`timescale 1ns / 1ps

module lamp_switch_display_io_board_test;
    import lsdio_pkg::*;

    localparam int DIGITS  = DIGITS_PER_BANK_DEF;
    localparam int COLUMNS = LAMP_COLUMNS_DEF;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;
    localparam int RANDOM_ITEMS = 1400;
    localparam int N_ROWS       = 24;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   bus_data;
        logic [SWITCH_W-1:0] switch_lines;
        logic                known;
        result_item_t        want;
    } stim_row_t;

    localparam result_item_t NO_VIEW = '0;

    // Rows marked known carry their result; the rest go through the predictor.
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ACT_SWITCH_READ, 16'h0000, 8'h01, 1'b1,
          '{8'h80, 3'd0, 8'h00, 32'h0000_0000, 4'h0, 5'd0, 16'h0000}},
        '{ACT_SWITCH_READ, 16'hFFFF, 8'hFF, 1'b1,
          '{8'hFF, 3'd0, 8'h00, 32'h0000_0000, 4'h0, 5'd0, 16'h0000}},
        '{ACT_SWITCH_READ, 16'h0000, 8'h00, 1'b1,
          '{8'h00, 3'd0, 8'h00, 32'h0000_0000, 4'h0, 5'd0, 16'h0000}},
        '{ACT_IRQ_ACK,     16'h0000, 8'h00, 1'b1,
          '{8'h89, 3'd0, 8'h00, 32'h0000_0000, 4'h0, 5'd0, 16'h0000}},
        '{ACT_LAMP_STROBE, 16'hFF00, 8'h00, 1'b1,
          '{8'h00, 3'd7, 8'h00, 32'h0000_0000, 4'h0, 5'd0, 16'h0000}},
        '{ACT_LAMP_ROW,    16'hFFFF, 8'h00, 1'b1,
          '{8'h00, 3'd7, 8'hFF, 32'h0000_0000, 4'h0, 5'd0, 16'h0000}},
        '{ACT_SOL_LOW,     16'hFFFF, 8'h00, 1'b1,
          '{8'h00, 3'd7, 8'hFF, 32'h0000_FFFF, 4'h0, 5'd0, 16'h0000}},
        '{ACT_SOL_HIGH,    16'hFFFF, 8'h00, 1'b1,
          '{8'h00, 3'd7, 8'hFF, 32'hFFFF_FFFF, 4'h0, 5'd0, 16'h0000}},
        '{ACT_SOL_LOW,     16'h0000, 8'h00, 1'b1,
          '{8'h00, 3'd7, 8'hFF, 32'hFFFF_0000, 4'h0, 5'd0, 16'h0000}},
        '{ACT_LAMP_STROBE, 16'h0100, 8'h00, 1'b0, NO_VIEW},
        '{ACT_LAMP_STROBE, 16'h0600, 8'h00, 1'b0, NO_VIEW},
        '{ACT_LAMP_ROW,    16'h5A00, 8'h00, 1'b0, NO_VIEW},
        '{ACT_CONTROL,     16'h0000, 8'h00, 1'b0, NO_VIEW},
        '{ACT_DISP_BANK0,  16'hFFFF, 8'h00, 1'b0, NO_VIEW},
        '{ACT_CONTROL,     16'h0400, 8'h00, 1'b0, NO_VIEW},
        '{ACT_CONTROL,     16'hFBFF, 8'h00, 1'b0, NO_VIEW},
        '{ACT_DISP_BANK1,  16'h0003, 8'h00, 1'b0, NO_VIEW},
        '{ACT_DISP_BANK0,  16'h8000, 8'h00, 1'b0, NO_VIEW},
        '{ACT_DISP_BANK1,  16'h0030, 8'h00, 1'b0, NO_VIEW},
        '{ACT_UNUSED_LO,   16'hFFFF, 8'hFF, 1'b0, NO_VIEW},
        '{ACT_UNUSED_HI,   16'hFFFF, 8'hFF, 1'b0, NO_VIEW},
        '{ACT_SOL_HIGH,    16'h0000, 8'h00, 1'b0, NO_VIEW},
        '{ACT_IRQ_ACK,     16'h0000, 8'h00, 1'b0, NO_VIEW},
        '{ACT_LAMP_STROBE, 16'h8000, 8'h00, 1'b0, NO_VIEW}
    };

    logic clk;
    logic rst_n;

    lsdio_bus_if    bus();
    lsdio_result_if result();

    lamp_switch_display_io_board u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bus    (bus),
        .result (result)
    );

    // Board state as the predictor sees it
    logic [IRQ_W-1:0]  vector_count;
    logic [COL_W-1:0]  strobe_col;
    logic [ROW_W-1:0]  lamp_mem [COLUMNS];
    logic [SOL_W-1:0]  sol_bits;
    logic              digit_synced;
    logic [DISP_W-1:0] digit_col;
    logic [SEG_W-1:0]  segment_mem [2*DIGITS];

    result_item_t due_board_views [$];
    int           mismatch_count;
    int           views_seen;
    bit           sender_no_gaps;
    bit           receiver_no_stalls;

    function automatic result_item_t predict_board(input bus_item_t it);
        result_item_t     v;
        logic [SUM_W-1:0] pos_sum;
        logic [DATA_W-1:0] d;
        int               slot;
        v = '0;
        d = it.bus_data;
        case (it.action)
            ACT_SWITCH_READ:
            begin
                for (int i = 0; i < SWITCH_W; i++)
                begin
                    v.read_value[SWITCH_W-1-i] = it.switch_lines[i];
                end
            end
            ACT_LAMP_STROBE:
            begin
                pos_sum = '0;
                for (int i = 0; i < 8; i++)
                begin
                    if (d[8+i])
                    begin
                        pos_sum = pos_sum + SUM_W'(i);
                    end
                end
                strobe_col = (pos_sum > SUM_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                              : COL_W'(pos_sum);
            end
            ACT_LAMP_ROW:
                lamp_mem[strobe_col % COLUMNS] = d[15:8];
            ACT_SOL_LOW:
                sol_bits[15:0] = d;
            ACT_SOL_HIGH:
                sol_bits[31:16] = d;
            ACT_CONTROL:
            begin
                if (digit_synced)
                begin
                    digit_col = DISP_W'((digit_col + 1) % DIGITS);
                end
                if (d[SYNC_BIT])
                begin
                    digit_synced = 1'b1;
                    digit_col    = '0;
                end
            end
            ACT_DISP_BANK0, ACT_DISP_BANK1:
            begin
                slot = (digit_col % DIGITS) + ((it.action == ACT_DISP_BANK1) ? DIGITS : 0);
                v.segment_pattern[0]    = |d[1:0];
                v.segment_pattern[1]    = d[2];
                v.segment_pattern[2]    = d[3];
                v.segment_pattern[3]    = |d[5:4];
                v.segment_pattern[4]    = d[6];
                v.segment_pattern[5]    = d[7];
                v.segment_pattern[6]    = d[15];
                v.segment_pattern[14:8] = d[14:8];
                segment_mem[slot]  = v.segment_pattern;
                v.segment_position = SEG_POS_W'(slot);
            end
            ACT_IRQ_ACK:
            begin
                v.read_value = (vector_count < 4'd8) ? IRQ_BASE_LO + READ_W'(vector_count)
                                                     : IRQ_BASE_HI + READ_W'(vector_count);
                vector_count = vector_count + 1'b1;
            end
            default:
                ;
        endcase
        v.lamp_column    = strobe_col;
        v.lamp_rows      = lamp_mem[strobe_col % COLUMNS];
        v.solenoid_word  = sol_bits;
        v.display_column = digit_col;
        return v;
    endfunction

    function automatic bus_item_t random_bus_item();
        bus_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        it.bus_data     = DATA_W'($urandom);
        it.switch_lines = SWITCH_W'($urandom);
        if (pick < 6)
        begin
            it.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        end
        else if (pick < 22)
        begin
            it.action = ACT_CONTROL;
        end
        else
        begin
            it.action = ACTION_W'($urandom_range(ACT_SWITCH_READ, ACT_IRQ_ACK));
        end
        // keep strobe sums low most of the time so columns below 7 get hit
        if (it.action == ACT_LAMP_STROBE && $urandom_range(0, 2) != 0)
        begin
            it.bus_data[15:8] = (8'h01 << $urandom_range(0, 7))
                              | (($urandom_range(0, 1) != 0) ? 8'h01 << $urandom_range(0, 3)
                                                              : 8'h00);
        end
        // resync rarely so the digit column walks through its wrap
        if (it.action == ACT_CONTROL)
        begin
            it.bus_data[SYNC_BIT] = ($urandom_range(0, 23) == 0);
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR view %0d: %s is %h, want %h", views_seen, what, got, want);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input bus_item_t it, input logic known, input result_item_t want);
        int           gap;
        result_item_t view;
        if ($urandom_range(0, 59) == 0)
        begin
            sender_no_gaps = !sender_no_gaps;
        end
        gap = sender_no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bus.valid        <= 1'b1;
        bus.action       <= it.action;
        bus.bus_data     <= it.bus_data;
        bus.switch_lines <= it.switch_lines;
        do
        begin
            @(posedge clk);
        end
        while (!bus.ready);
        view = predict_board(it);
        due_board_views.push_back(known ? want : view);
        @(negedge clk);
    endtask

    // Drop valid and hold until every result is back.
    task automatic wait_drained();
        bus.valid <= 1'b0;
        while (due_board_views.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side
    initial
    begin
        int           hold;
        result_item_t got;
        result_item_t want;
        result.ready       = 1'b0;
        receiver_no_stalls = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 59) == 0)
            begin
                receiver_no_stalls = !receiver_no_stalls;
            end
            hold = receiver_no_stalls ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                result.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            result.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!result.valid);
            got = '{result.read_value, result.lamp_column, result.lamp_rows,
                    result.solenoid_word, result.display_column,
                    result.segment_position, result.segment_pattern};
            if (due_board_views.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'(got.read_value), '0);
            end
            else
            begin
                want = due_board_views.pop_front();
                if (got.read_value != want.read_value)
                    report_mismatch("read_value", 32'(got.read_value),
                                    32'(want.read_value));
                if (got.lamp_column != want.lamp_column)
                    report_mismatch("lamp_column", 32'(got.lamp_column),
                                    32'(want.lamp_column));
                if (got.lamp_rows != want.lamp_rows)
                    report_mismatch("lamp_rows", 32'(got.lamp_rows), 32'(want.lamp_rows));
                if (got.solenoid_word != want.solenoid_word)
                    report_mismatch("solenoid_word", got.solenoid_word, want.solenoid_word);
                if (got.display_column != want.display_column)
                    report_mismatch("display_column", 32'(got.display_column),
                                    32'(want.display_column));
                if (got.segment_position != want.segment_position)
                    report_mismatch("segment_position", 32'(got.segment_position),
                                    32'(want.segment_position));
                if (got.segment_pattern != want.segment_pattern)
                    report_mismatch("segment_pattern", 32'(got.segment_pattern),
                                    32'(want.segment_pattern));
            end
            views_seen++;
            @(negedge clk);
        end
    end

    // Bus side
    initial
    begin
        bus_item_t it;
        rst_n            = 1'b0;
        bus.valid        = 1'b0;
        bus.action       = '0;
        bus.bus_data     = '0;
        bus.switch_lines = '0;
        mismatch_count   = 0;
        views_seen       = 0;
        sender_no_gaps   = 1'b0;
        vector_count     = IRQ_RESET;
        strobe_col       = '0;
        sol_bits         = '0;
        digit_synced     = 1'b0;
        digit_col        = '0;
        for (int i = 0; i < COLUMNS; i++)
        begin
            lamp_mem[i] = '0;
        end
        for (int i = 0; i < 2*DIGITS; i++)
        begin
            segment_mem[i] = '0;
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            it.action       = DIRECTED_ROWS[r].action;
            it.bus_data     = DIRECTED_ROWS[r].bus_data;
            it.switch_lines = DIRECTED_ROWS[r].switch_lines;
            send_item(it, DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                wait_drained();
            end
            send_item(random_bus_item(), 1'b0, NO_VIEW);
        end
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/lsdio_pkg.sv
src/lsdio_bus_if.sv
src/lsdio_result_if.sv
src/lsdio_update.sv
src/lamp_switch_display_io_board.sv
sim/lamp_switch_display_io_board_test.sv
